@@ design/twa_pkg.sv @@
// Package for the time-window weighted average block.
// Holds widths, action codes, read selectors and the controller/datapath structs.
// No dependencies.
package twa_pkg;

   localparam int RING_DEPTH = 16;
   localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);
   localparam int TIME_W     = 63;
   localparam int VAL_W      = 32;
   localparam int COUNT_W    = 5;
   localparam int PROD_W     = 96;
   localparam int ACC_W      = PROD_W + 1;
   localparam int DIV_BITS   = PROD_W;
   localparam int DIV_CNT_W  = $clog2(DIV_BITS);
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 104;

   localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(1000000);

   typedef enum logic [2:0] {
      ACT_ADD   = 3'd0,
      ACT_AVG   = 3'd1,
      ACT_SIZE  = 3'd2,
      ACT_SPAN  = 3'd3,
      ACT_CLEAR = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      RD_OLD      = 2'd0,
      RD_NEW      = 2'd1,
      RD_POS_NEXT = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic       accept;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       clear_ring;
      logic       guard_clr;
      logic       old_adv;
      logic       add_first;
      logic       add_write;
      logic       avg_fallback;
      logic       avg_single;
      logic       walk_init;
      logic       walk_load;
      logic       walk_step;
      logic       walk_diff;
      logic       mul_lo;
      logic       mul_hi;
      logic       acc_add;
      logic       div_init;
      logic       div_step;
      logic       div_end;
      logic       span_calc;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       empty;
      logic       expired;
      logic       guard_ok;
      logic       old_eq_new;
      logic       pos_ne_new;
      logic       total_zero;
      logic       div_last;
   } status_type;

endpackage

@@ design/twa_dp.sv @@
// Datapath of the time-window weighted average block: sample ring memory,
// ring pointers, trapezoid accumulator, serial divider and result register.
// Depends on twa_pkg.
module twa_dp
   import twa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_wen,
   input  logic [TIME_W-1:0]     csr_wdata,
   input  logic [2:0]            in_action,
   input  logic [TIME_W-1:0]     in_timestamp,
   input  logic [VAL_W-1:0]      in_sample,
   input  logic [VAL_W-1:0]      in_fallback,
   output logic [VAL_W-1:0]      out_average,
   output logic [COUNT_W-1:0]    out_count,
   output logic [TIME_W-1:0]     out_span,
   output logic                  out_empty
);

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      if (s == SLOT_W'(RING_DEPTH - 1)) return '0;
      return s + SLOT_W'(1);
   endfunction

   logic [TIME_W-1:0] mem_time [RING_DEPTH];
   logic [VAL_W-1:0]  mem_val  [RING_DEPTH];

   logic [TIME_W-1:0] window_ff;
   logic [SLOT_W-1:0] oldest_ff, newest_ff, pos_ff;
   logic              empty_ff;
   logic [CNT_W-1:0]  guard_ff;
   logic [2:0]        action_ff;
   logic [TIME_W-1:0] now_ff;
   logic [VAL_W-1:0]  sample_ff, fallback_ff;
   logic [TIME_W-1:0] rd_time_ff;
   logic [VAL_W-1:0]  rd_val_ff;
   logic [TIME_W-1:0] t_ff, d_ff, total_ff, span_ff;
   logic [VAL_W-1:0]  v_ff, avg_ff;
   logic [VAL_W:0]    mag_ff;
   logic              sneg_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [DIV_BITS-1:0] dvd_ff;
   logic [TIME_W-1:0] rem_ff;
   logic [VAL_W-1:0]  q_ff;
   logic              qneg_ff;
   logic [DIV_CNT_W-1:0] dcnt_ff;
   logic [VAL_W-1:0]  rsp_avg_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [TIME_W-1:0] rsp_span_ff;
   logic              rsp_empty_ff;

   logic [SLOT_W-1:0] rd_addr, wr_addr;
   logic              wr_en;
   logic [TIME_W-1:0] wr_time;
   logic [TIME_W:0]   rd_limit;
   logic              now_after_rd;
   logic [SLOT_W-1:0] new_next;
   logic [VAL_W:0]    pair_sum;
   logic [VAL_W:0]    pair_mag;
   logic [PROD_W-1:0] area;
   logic [ACC_W-1:0]  area_signed;
   logic [ACC_W-1:0]  acc_abs;
   logic [TIME_W:0]   rem_sh;
   logic [CNT_W-1:0]  live;
   logic [64:0]       part_lo;
   logic [63:0]       part_hi;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_OLD:      rd_addr = oldest_ff;
         RD_NEW:      rd_addr = newest_ff;
         RD_POS_NEXT: rd_addr = next_slot(pos_ff);
         default:     rd_addr = oldest_ff;
      endcase
   end

   assign rd_limit     = {1'b0, rd_time_ff} + {1'b0, window_ff};
   assign now_after_rd = now_ff > rd_time_ff;
   assign new_next     = next_slot(newest_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = newest_ff;
      wr_time = now_ff;
      if (cmd.add_first) begin
         wr_en   = 1'b1;
         wr_addr = '0;
      end else if (cmd.add_write) begin
         wr_en = 1'b1;
         if (now_after_rd) begin
            wr_addr = new_next;
         end else begin
            wr_time = rd_time_ff;
         end
      end
   end

   // Neighbor pair sum and its magnitude; one extra bit holds the sign.
   assign pair_sum    = {v_ff[VAL_W-1], v_ff} + {rd_val_ff[VAL_W-1], rd_val_ff};
   assign pair_mag    = pair_sum[VAL_W] ? (~pair_sum + (VAL_W+1)'(1)) : pair_sum;
   assign area        = prod_ff >> 1;
   assign area_signed = sneg_ff ? (~{1'b0, area} + ACC_W'(1)) : {1'b0, area};
   assign acc_abs     = acc_ff[ACC_W-1] ? (~acc_ff + ACC_W'(1)) : acc_ff;
   assign rem_sh      = {rem_ff, dvd_ff[DIV_BITS-1]};

   // The time difference is multiplied in two halves, the low half first.
   assign part_lo = d_ff[31:0] * mag_ff;
   assign part_hi = d_ff[TIME_W-1:32] * mag_ff;

   always_comb begin
      if (empty_ff) begin
         live = '0;
      end else if (oldest_ff > newest_ff) begin
         live = CNT_W'(RING_DEPTH) + CNT_W'(newest_ff) - CNT_W'(oldest_ff) + CNT_W'(1);
      end else begin
         live = CNT_W'(newest_ff) - CNT_W'(oldest_ff) + CNT_W'(1);
      end
   end

   always_comb begin
      status.action     = action_ff;
      status.empty      = empty_ff;
      status.expired    = rd_limit < {1'b0, now_ff};
      status.guard_ok   = guard_ff < CNT_W'(RING_DEPTH);
      status.old_eq_new = oldest_ff == newest_ff;
      status.pos_ne_new = pos_ff != newest_ff;
      status.total_zero = total_ff == '0;
      status.div_last   = dcnt_ff == DIV_CNT_W'(DIV_BITS - 1);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_time[wr_addr] <= wr_time;
         mem_val[wr_addr]  <= sample_ff;
      end
      if (cmd.rd_en) begin
         rd_time_ff <= mem_time[rd_addr];
         rd_val_ff  <= mem_val[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         oldest_ff <= '0;
         newest_ff <= '0;
         empty_ff  <= 1'b1;
      end else begin
         if (csr_wen) window_ff <= csr_wdata;
         if (cmd.clear_ring) begin
            empty_ff  <= 1'b1;
            oldest_ff <= '0;
            newest_ff <= '0;
         end
         if (cmd.old_adv) oldest_ff <= next_slot(oldest_ff);
         if (cmd.add_first) begin
            empty_ff  <= 1'b0;
            oldest_ff <= '0;
            newest_ff <= '0;
         end
         if (cmd.add_write && now_after_rd) begin
            newest_ff <= new_next;
            if (new_next == oldest_ff) oldest_ff <= next_slot(oldest_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff   <= in_action;
         now_ff      <= in_timestamp;
         sample_ff   <= in_sample;
         fallback_ff <= in_fallback;
         avg_ff      <= '0;
         span_ff     <= '0;
      end
      if (cmd.guard_clr) guard_ff <= '0;
      if (cmd.old_adv)   guard_ff <= guard_ff + CNT_W'(1);
      if (cmd.avg_fallback) avg_ff <= fallback_ff;
      if (cmd.avg_single)   avg_ff <= rd_val_ff;
      if (cmd.walk_init) begin
         pos_ff   <= oldest_ff;
         guard_ff <= '0;
         acc_ff   <= '0;
         total_ff <= '0;
      end
      if (cmd.walk_load) begin
         t_ff <= rd_time_ff;
         v_ff <= rd_val_ff;
      end
      if (cmd.walk_step) begin
         pos_ff   <= next_slot(pos_ff);
         guard_ff <= guard_ff + CNT_W'(1);
      end
      if (cmd.walk_diff) begin
         d_ff     <= rd_time_ff - t_ff;
         total_ff <= total_ff + (rd_time_ff - t_ff);
         mag_ff   <= pair_mag;
         sneg_ff  <= pair_sum[VAL_W];
         t_ff     <= rd_time_ff;
         v_ff     <= rd_val_ff;
      end
      if (cmd.mul_lo) prod_ff <= PROD_W'(part_lo);
      if (cmd.mul_hi) prod_ff <= prod_ff + {part_hi, 32'd0};
      if (cmd.acc_add) acc_ff <= acc_ff + area_signed;
      if (cmd.div_init) begin
         qneg_ff <= acc_ff[ACC_W-1];
         dvd_ff  <= acc_abs[DIV_BITS-1:0];
         rem_ff  <= '0;
         q_ff    <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem_sh >= {1'b0, total_ff}) begin
            rem_ff <= TIME_W'(rem_sh - {1'b0, total_ff});
            q_ff   <= {q_ff[VAL_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[TIME_W-1:0];
            q_ff   <= {q_ff[VAL_W-2:0], 1'b0};
         end
         dvd_ff  <= dvd_ff << 1;
         dcnt_ff <= dcnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.div_end) avg_ff <= qneg_ff ? (~q_ff + VAL_W'(1)) : q_ff;
      if (cmd.span_calc) begin
         span_ff <= (!empty_ff && now_after_rd) ? (now_ff - rd_time_ff) : '0;
      end
      if (cmd.rsp_load) begin
         rsp_avg_ff   <= avg_ff;
         rsp_count_ff <= COUNT_W'(live);
         rsp_span_ff  <= span_ff;
         rsp_empty_ff <= empty_ff;
      end
   end

   assign out_average = rsp_avg_ff;
   assign out_count   = rsp_count_ff;
   assign out_span    = rsp_span_ff;
   assign out_empty   = rsp_empty_ff;

endmodule

@@ design/twa_ctrl.sv @@
// Controller of the time-window weighted average block: sequences expiry,
// the action, the averaging walk, the division and the result transfer.
// Depends on twa_pkg.
module twa_ctrl
   import twa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_EXP_NEW_RD, S_EXP_NEW_CHK, S_EXP_OLD_RD, S_EXP_OLD_CHK,
      S_ACT, S_ADD_CHK, S_AVG_START, S_AVG_SINGLE, S_AVG_FIRST, S_AVG_RD,
      S_AVG_DIFF, S_MUL_LO, S_MUL_HI, S_AVG_ACC, S_DIV_START, S_DIV_STEP,
      S_DIV_END, S_SPAN_RD, S_SPAN_CHK, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      cmd.rd_sel = RD_OLD;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXP_NEW_RD;
            end
         end
         S_EXP_NEW_RD: begin
            if (status.empty) begin
               state_in = S_ACT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEW;
               state_in   = S_EXP_NEW_CHK;
            end
         end
         S_EXP_NEW_CHK: begin
            if (status.expired) begin
               cmd.clear_ring = 1'b1;
               state_in       = S_ACT;
            end else begin
               cmd.guard_clr = 1'b1;
               state_in      = S_EXP_OLD_RD;
            end
         end
         S_EXP_OLD_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_EXP_OLD_CHK;
         end
         S_EXP_OLD_CHK: begin
            if (status.expired && status.guard_ok) begin
               cmd.old_adv = 1'b1;
               state_in    = S_EXP_OLD_RD;
            end else begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            unique case (status.action)
               ACT_ADD: begin
                  if (status.empty) begin
                     cmd.add_first = 1'b1;
                     state_in      = S_AVG_START;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_NEW;
                     state_in   = S_ADD_CHK;
                  end
               end
               ACT_AVG: begin
                  if (status.empty) begin
                     cmd.avg_fallback = 1'b1;
                     state_in         = S_SPAN_RD;
                  end else begin
                     state_in = S_AVG_START;
                  end
               end
               ACT_CLEAR: begin
                  cmd.clear_ring = 1'b1;
                  state_in       = S_SPAN_RD;
               end
               default: state_in = S_SPAN_RD;
            endcase
         end
         S_ADD_CHK: begin
            cmd.add_write = 1'b1;
            state_in      = S_AVG_START;
         end
         S_AVG_START: begin
            cmd.rd_en = 1'b1;
            if (status.old_eq_new) begin
               cmd.rd_sel = RD_NEW;
               state_in   = S_AVG_SINGLE;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = S_AVG_FIRST;
            end
         end
         S_AVG_SINGLE: begin
            cmd.avg_single = 1'b1;
            state_in       = S_SPAN_RD;
         end
         S_AVG_FIRST: begin
            cmd.walk_load = 1'b1;
            state_in      = S_AVG_RD;
         end
         S_AVG_RD: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_POS_NEXT;
            cmd.walk_step = 1'b1;
            state_in      = S_AVG_DIFF;
         end
         S_AVG_DIFF: begin
            cmd.walk_diff = 1'b1;
            state_in      = S_MUL_LO;
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_AVG_ACC;
         end
         S_AVG_ACC: begin
            cmd.acc_add = 1'b1;
            state_in    = (status.pos_ne_new && status.guard_ok) ? S_AVG_RD : S_DIV_START;
         end
         S_DIV_START: begin
            if (status.total_zero) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEW;
               state_in   = S_AVG_SINGLE;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV_STEP;
            end
         end
         S_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_DIV_END;
         end
         S_DIV_END: begin
            cmd.div_end = 1'b1;
            state_in    = S_SPAN_RD;
         end
         S_SPAN_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_SPAN_CHK;
         end
         S_SPAN_CHK: begin
            cmd.span_calc = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ design/time_window_weighted_average_top.sv @@
// Time-window weighted average top level, built on twa_pkg, twa_ctrl and twa_dp. Each item is
// accepted, expired samples are retired, then the action runs; an average (also run after an
// add) walks each neighbor pair and ends in a bit-serial division. One item at a time: no new
// item is taken until the result of the last is loaded into the result register.
// Reset (synchronous, active high) empties the ring and loads the window with 1000000.
module time_window_weighted_average_top
   import twa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata, lowest bit up: timestamp[62:0], sample_value[94:63], fallback_value[126:95],
   // one zero pad bit.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: action[2:0].
   input  logic [2:0]            req_tuser,
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata, lowest bit up: average[31:0], sample_count[36:32], span[99:37],
   // is_empty[100], three zero pad bits.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Window length register.
   input  logic                  csr_wen,
   input  logic [TIME_W-1:0]     csr_wdata
);

   // The controller sequences each transfer through the datapath; the two share
   // only the command and status structs below.
   cmd_type    cmd;
   status_type status;

   logic [VAL_W-1:0]   average;
   logic [COUNT_W-1:0] sample_count;
   logic [TIME_W-1:0]  span;
   logic               is_empty;

   twa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   twa_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .in_action    (req_tuser),
      .in_timestamp (req_tdata[62:0]),
      .in_sample    (req_tdata[94:63]),
      .in_fallback  (req_tdata[126:95]),
      .out_average  (average),
      .out_count    (sample_count),
      .out_span     (span),
      .out_empty    (is_empty)
   );

   // The result register holds its payload until the transfer completes.
   assign rsp_tdata = {3'b000, is_empty, span, sample_count, average};

   // The ring never reports more live samples than it holds.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[36:32] <= COUNT_W'(RING_DEPTH)))
      else $error("sample count exceeds ring depth");

   // The empty flag and the live count agree.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[100] == (rsp_tdata[36:32] == '0)))
      else $error("empty flag disagrees with sample count");

   // An empty ring always reports a zero span.
   a_empty_span: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[100]) |-> (rsp_tdata[99:37] == '0))
      else $error("nonzero span on empty ring");

   // Items are processed one at a time: no second transfer right after one.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while busy");

endmodule
